// ----- rtl/core/w2s_pkg.sv -----
// Package: shared types and constants for the world-to-screen projection block.
`default_nettype none
package w2s_pkg;
    localparam int CoefW   = 48;
    localparam int PointW  = 32;
    localparam int AccW    = 128;
    localparam int DistW   = 24;
    localparam int NumCoef = 12;
    localparam int IdxW    = 4;

    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_TOP_OFFSET    = 3'd2;
    localparam logic [2:0] CFG_BOTTOM_OFFSET = 3'd3;
    localparam logic [2:0] CFG_MIN_DEPTH     = 3'd4;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    typedef logic signed [AccW-1:0] acc_t;
    typedef logic signed [CoefW-1:0] coef_t;
endpackage
`default_nettype wire

// ----- rtl/core/w2s_divider.sv -----
// Restoring divider: one quotient bit per cycle, 128-bit magnitude.
`default_nettype none
module w2s_divider
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [w2s_pkg::AccW-1:0] num,
    input  wire logic [w2s_pkg::AccW-1:0] den,
    output logic                          done,
    output logic [w2s_pkg::AccW-1:0]      quot
);
    import w2s_pkg::*;

    logic [AccW-1:0] rem_reg, rem_next;
    logic [AccW-1:0] q_reg, q_next;
    logic [AccW-1:0] d_reg, d_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [AccW:0]   trial;
    logic [AccW:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[AccW-1]};
        trial     = shifted - {1'b0, d_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            d_next    = den;
            cnt_next  = 8'(AccW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[AccW])
            begin
                rem_next = trial[AccW-1:0];
                q_next   = {q_reg[AccW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[AccW-1:0];
                q_next   = {q_reg[AccW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

// ----- rtl/core/world_to_screen_projection_top.sv -----
// Top level: view-matrix store, digit-serial dot products, dividers and result register.
// Usage: the in channel takes load words (action 0, one coefficient) and project
// words (action 1, one world point). A load word is taken while idle, in_ready
// stays high, and it gives no result. A project word gives one out word. Dot
// products run on one 48x9 multiplier, one 8-bit digit of the point operand per
// cycle, top digit first: each term runs its digits in S_MUL and is added in
// S_ACC, over the 12 matrix terms and the two offset terms. Distance then takes a
// divide by 100 in S_DIST, 6 bits a cycle. When visible, each of the three ratios
// takes a shift-add scaling by the half screen size in S_NUM, a divider start in
// S_DIV and a restoring divide in S_WAITD, where the quotient is taken. One word
// is in flight at a time; in_ready is high only when idle. The result sits in an
// output register until taken; out_valid holds while the receiver stalls, and the
// next in word waits. Reset clears the view matrix to zero and config registers to
// 1920, 1080, 85, -95, 1678.
// Config writes are taken at any time and should be done while idle.
`default_nettype none
module world_to_screen_projection_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [24:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic [3:0]         coef_index,
    input  wire logic signed [47:0] coef_value,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    visible,
    output logic signed [31:0]      screen_x,
    output logic signed [31:0]      screen_y,
    output logic signed [31:0]      box_height,
    output logic signed [23:0]      distance
);
    import w2s_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_DIST, S_NUM, S_DIV, S_WAITD, S_OUT
    } state_t;

    localparam logic signed [63:0] RatioLim = 64'sh2000_0000_0000_0000;

    state_t state_reg;
    logic [13:0] sw_reg, sh_reg;
    logic signed [10:0] top_reg, bot_reg;
    logic [24:0] mind_reg;
    coef_t mat_reg [NumCoef];
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [3:0] step_reg;
    logic [1:0] dig_reg;
    acc_t prod_reg;
    acc_t w_reg, ax_reg, ay_reg, ab_reg;
    logic [2:0] div_sel_reg;
    logic [AccW-1:0] dnum_reg, dq_reg;
    logic [4:0] dcnt_reg;
    logic [AccW-1:0] drem_reg;
    logic [12:0] hsh_reg;
    acc_t nacc_reg;
    logic signed [63:0] qy_reg;
    logic vis_reg;
    logic signed [31:0] sx_reg, sy_reg, bh_reg;
    logic signed [23:0] dist_reg;
    logic nneg_reg;

    // multiplier operand select, one 8-bit digit of m_b per cycle, top digit first
    coef_t m_a;
    logic signed [31:0] m_b;
    logic signed [8:0] m_d;
    logic signed [56:0] m_pd;
    acc_t prod_next;
    always_comb
    begin
        case (step_reg)
            4'd0:    m_a = mat_reg[8];
            4'd1:    m_a = mat_reg[9];
            4'd2:    m_a = mat_reg[10];
            4'd3:    m_a = mat_reg[11];
            4'd4:    m_a = mat_reg[0];
            4'd5:    m_a = mat_reg[1];
            4'd6:    m_a = mat_reg[2];
            4'd7:    m_a = mat_reg[3];
            4'd8:    m_a = mat_reg[4];
            4'd9:    m_a = mat_reg[5];
            4'd10:   m_a = mat_reg[6];
            4'd11:   m_a = mat_reg[7];
            4'd12:   m_a = mat_reg[6];
            4'd13:   m_a = mat_reg[6];
            default: m_a = '0;
        endcase
        if (step_reg == 4'd12)
            m_b = {{13{top_reg[10]}}, top_reg, 8'd0};
        else if (step_reg == 4'd13)
            m_b = {{13{bot_reg[10]}}, bot_reg, 8'd0};
        else
        begin
            case (step_reg[1:0])
                2'd0:    m_b = px_reg;
                2'd1:    m_b = py_reg;
                2'd2:    m_b = pz_reg;
                default: m_b = 32'sd256;
            endcase
        end
        case (dig_reg)
            2'd3:    m_d = {m_b[31], m_b[31:24]};
            2'd2:    m_d = {1'b0, m_b[23:16]};
            2'd1:    m_d = {1'b0, m_b[15:8]};
            default: m_d = {1'b0, m_b[7:0]};
        endcase
        m_pd = m_a * m_d;
        prod_next = {{71{m_pd[56]}}, m_pd}
                    + ((dig_reg == 2'd3) ? '0 : {prod_reg[AccW-9:0], 8'd0});
    end

    // divide-by-100 digit step on the 96-bit depth magnitude, 6 bits a cycle
    acc_t aw;
    logic [95:0] wint;
    assign aw   = w_reg[AccW-1] ? -w_reg : w_reg;
    assign wint = aw[127:32];

    logic [AccW-1:0] dist_rem_sh;
    logic [AccW-1:0] dist_q_sh;
    always_comb
    begin
        logic [12:0] r;
        r = 13'(drem_reg);
        dist_q_sh = dq_reg;
        for (int i = 0; i < 6; i++)
        begin
            r = {r[11:0], dnum_reg[95 - i]};
            dist_q_sh = {dist_q_sh[AccW-2:0], 1'b0};
            if (r >= 13'd100)
            begin
                r = r - 13'd100;
                dist_q_sh[0] = 1'b1;
            end
        end
        dist_rem_sh = AccW'(r);
    end

    // ratio numerator: shift-add scaling by the half screen size, one bit a cycle
    logic div_start;
    logic div_done;
    logic [AccW-1:0] div_quot;
    logic [AccW-1:0] div_num;
    acc_t n_src;
    acc_t nacc_next;
    acc_t num_s;
    logic [AccW-1:0] wmag;
    always_comb
    begin
        unique case (div_sel_reg)
            3'd0:    n_src = ax_reg;
            3'd1:    n_src = ay_reg;
            default: n_src = ab_reg;
        endcase
        nacc_next = {nacc_reg[AccW-2:0], 1'b0} + (hsh_reg[12] ? n_src : '0);
        num_s     = {nacc_reg[AccW-9:0], 8'd0};
        div_num   = num_s[AccW-1] ? -num_s : num_s;
    end
    assign wmag = w_reg;

    w2s_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (wmag),
        .done  (div_done),
        .quot  (div_quot)
    );

    logic signed [63:0] q_sat;
    always_comb
    begin
        logic signed [63:0] mag;
        if (w_reg == '0)
            mag = (dnum_reg != '0) ? RatioLim : 64'sd0;
        else if (div_quot[AccW-1:61] != '0 && div_quot != AccW'(RatioLim))
            mag = RatioLim;
        else
            mag = $signed(div_quot[63:0]);
        q_sat = nneg_reg ? -mag : mag;
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    logic signed [65:0] hw66, hh66;
    assign hw66 = 66'($signed({1'b0, sw_reg[13:1], 8'd0}));
    assign hh66 = 66'($signed({1'b0, sh_reg[13:1], 8'd0}));

    logic vis_cmp;
    assign vis_cmp = w_reg >= $signed({95'd0, mind_reg, 8'd0});

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sw_reg    <= 14'd1920;
            sh_reg    <= 14'd1080;
            top_reg   <= 11'sd85;
            bot_reg   <= -11'sd95;
            mind_reg  <= 25'd1678;
            for (int i = 0; i < NumCoef; i++)
                mat_reg[i] <= '0;
            step_reg  <= '0;
            dig_reg   <= 2'd3;
            dcnt_reg  <= '0;
            div_sel_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SCREEN_WIDTH:  sw_reg   <= cfg_data[13:0];
                    CFG_SCREEN_HEIGHT: sh_reg   <= cfg_data[13:0];
                    CFG_TOP_OFFSET:    top_reg  <= cfg_data[10:0];
                    CFG_BOTTOM_OFFSET: bot_reg  <= cfg_data[10:0];
                    CFG_MIN_DEPTH:     mind_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (action == ACT_LOAD)
                        begin
                            if (coef_index < 4'(NumCoef))
                                mat_reg[coef_index] <= coef_value;
                        end
                        else
                        begin
                            px_reg <= point_x;
                            py_reg <= point_y;
                            pz_reg <= point_z;
                            step_reg <= '0;
                            dig_reg <= 2'd3;
                            w_reg <= '0;
                            ax_reg <= '0;
                            ay_reg <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg <= prod_next;
                    dig_reg  <= dig_reg - 2'd1;
                    if (dig_reg == 2'd0)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (step_reg < 4'd4)
                        w_reg <= w_reg + prod_reg;
                    else if (step_reg < 4'd8)
                        ax_reg <= ax_reg + prod_reg;
                    else if (step_reg < 4'd12)
                        ay_reg <= ay_reg + prod_reg;
                    else if (step_reg == 4'd12)
                    begin
                        ab_reg <= ay_reg;
                        ay_reg <= ay_reg + prod_reg;
                    end
                    else
                        ab_reg <= ab_reg + prod_reg;
                    if (step_reg == 4'd13)
                    begin
                        dnum_reg  <= {32'd0, wint};
                        drem_reg  <= '0;
                        dq_reg    <= '0;
                        dcnt_reg  <= 5'd16;
                        state_reg <= S_DIST;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DIST:
                begin
                    dnum_reg <= {dnum_reg[AccW-7:0], 6'd0};
                    drem_reg <= dist_rem_sh;
                    dq_reg   <= dist_q_sh;
                    if (dcnt_reg == 5'd1)
                    begin
                        if (w_reg[AccW-1])
                            dist_reg <= (dist_q_sh > AccW'(8388608)) ? -24'sd8388608
                                        : -dist_q_sh[23:0];
                        else
                            dist_reg <= (dist_q_sh > AccW'(8388607)) ? 24'sd8388607
                                        : dist_q_sh[23:0];
                        vis_reg <= vis_cmp;
                        sx_reg <= '0;
                        sy_reg <= '0;
                        bh_reg <= '0;
                        nacc_reg <= '0;
                        hsh_reg <= sw_reg[13:1];
                        dcnt_reg <= 5'd13;
                        div_sel_reg <= 3'd0;
                        state_reg <= vis_cmp ? S_NUM : S_OUT;
                    end
                    else
                        dcnt_reg <= dcnt_reg - 5'd1;
                end
                S_NUM:
                begin
                    nacc_reg <= nacc_next;
                    hsh_reg  <= {hsh_reg[11:0], 1'b0};
                    dcnt_reg <= dcnt_reg - 5'd1;
                    if (dcnt_reg == 5'd1)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dnum_reg  <= div_num;
                    nneg_reg  <= num_s[AccW-1];
                    state_reg <= S_WAITD;
                end
                S_WAITD:
                begin
                    if (div_done)
                    begin
                        nacc_reg <= '0;
                        hsh_reg  <= sh_reg[13:1];
                        dcnt_reg <= 5'd13;
                        if (div_sel_reg == 3'd0)
                        begin
                            sx_reg <= sat32(hw66 + 66'(q_sat));
                            div_sel_reg <= 3'd1;
                            state_reg <= S_NUM;
                        end
                        else if (div_sel_reg == 3'd1)
                        begin
                            qy_reg <= q_sat;
                            sy_reg <= sat32(hh66 - 66'(q_sat));
                            div_sel_reg <= 3'd2;
                            state_reg <= S_NUM;
                        end
                        else
                        begin
                            bh_reg <= sat32((hh66 - 66'(q_sat)) - (hh66 - 66'(qy_reg)));
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = (state_reg == S_OUT);
    assign visible    = vis_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign box_height = bh_reg;
    assign distance   = dist_reg;
endmodule
`default_nettype wire

// ----- rtl/core/w2s_checker.sv -----
// Checker: port-level properties of the projection block, bound to the top level.
`default_nettype none
module w2s_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic visible,
    input wire logic [31:0] screen_x,
    input wire logic [23:0] distance
);
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("in ready while result held");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("result dropped");
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> screen_x == 32'd0) else $error("hidden not zero");
    a_no_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind world_to_screen_projection_top w2s_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible),
    .screen_x  (screen_x),
    .distance  (distance)
);
`default_nettype wire
